// ===== hw/rtl/dequantize_int4_blockwise_defines.svh =====
// Assertion macros for the blockwise int4 dequantizer checker.
// Depends on nothing; included by the checker file only.
`ifndef DEQUANTIZE_INT4_BLOCKWISE_DEFINES_SVH
`define DEQUANTIZE_INT4_BLOCKWISE_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define DQI4_ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("dqi4 implication check failed");

// Next-cycle implication, disabled while dis is high.
`define DQI4_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("dqi4 next-cycle check failed");

`endif

// ===== hw/rtl/dqi4_pkg.sv =====
// Shared types, field widths, codes and constants of the int4 dequantizer.
// Depends on nothing; used by every other file but the defines header, through dqi4_pkg:: names or an import.
package dqi4_pkg;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 12;
  localparam int DATA_W     = 16;
  localparam int CODES_W    = 32;
  localparam int CODE_W     = 4;
  localparam int LANE_W     = 3;
  localparam int RESULT_W   = 20;
  localparam int COLUMN_W   = 12;
  localparam int ZP_BYTE_W  = 8;

  // Parameter defaults for the top level
  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int MAX_GROUPS_DEF  = 512;
  localparam int SCALE_BITS_DEF  = 16;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_SCALE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ZP      = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REORDER = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DEQUANT = 2'd3;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZP_ENABLE       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REORDER_ENABLE  = 2'd3;

  localparam logic [3:0]  BLOCK_SIZE_LOG2_RST = 4'd5;
  localparam logic [12:0] ROW_LENGTH_RST      = 13'd4096;

  // Fixed zero point when the table is off
  localparam logic [CODE_W-1:0] ZP_FIXED = 4'd8;

  // Saturation bounds of the result
  localparam int RES_MAX = 524287;
  localparam int RES_MIN = -524288;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [3:0]  block_size_log2;
    logic [12:0] row_length;
    logic        zero_points_enabled;
    logic        reorder_enabled;
  } cfg_t;

  // One classified command; last_lane is the final lane to emit for a dequantize
  typedef struct packed {
    logic [ACTION_W-1:0] kind;
    logic [INDEX_W-1:0]  addr;
    logic [DATA_W-1:0]   data;
    logic [CODES_W-1:0]  codes;
    logic [LANE_W-1:0]   last_lane;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== hw/rtl/dqi4_in_if.sv =====
// Input channel of the int4 dequantizer: valid/ready plus item fields.
// Depends on dqi4_pkg for the field widths.
interface dqi4_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dqi4_pkg::ACTION_W-1:0]        action;
  logic [dqi4_pkg::INDEX_W-1:0]         index;
  logic signed [dqi4_pkg::DATA_W-1:0]   data_value;
  logic [dqi4_pkg::CODES_W-1:0]         packed_codes;

  modport source (output valid, action, index, data_value, packed_codes, input ready);
  modport sink   (input valid, action, index, data_value, packed_codes, output ready);
endinterface

// ===== hw/rtl/dqi4_out_if.sv =====
// Result channel of the int4 dequantizer: valid/ready plus result fields.
// Depends on dqi4_pkg for the field widths.
interface dqi4_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dqi4_pkg::RESULT_W-1:0]  dequantized_value;
  logic [dqi4_pkg::COLUMN_W-1:0]         column;
  logic                                  last;

  modport source (output valid, dequantized_value, column, last, input ready);
  modport sink   (input valid, dequantized_value, column, last, output ready);
endinterface

// ===== hw/rtl/dqi4_front.sv =====
// Front end: accepts input transactions, drops out-of-range writes and empty
// words, and turns the rest into queue commands. Depends on dqi4_pkg, dqi4_in_if.
module dqi4_front #(
  parameter int MAX_COLUMNS = dqi4_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_GROUPS  = dqi4_pkg::MAX_GROUPS_DEF
) (
  dqi4_in_if.sink           item,
  input  dqi4_pkg::cfg_t    cfg,
  input  logic              q_full,
  output dqi4_pkg::q_push_t q_push
);

  localparam int ZP_DEPTH = (MAX_GROUPS + 1) / 2;
  localparam int LW = ($clog2(MAX_COLUMNS + 1) > 13) ? $clog2(MAX_COLUMNS + 1) : 13;

  logic [LW-1:0] limit;
  logic [LW-1:0] start;
  logic [LW-1:0] remain;
  logic          keep;
  logic [dqi4_pkg::LANE_W-1:0] last_lane;

  assign item.ready = !q_full;

  // Column limit is the smaller of row length and table size
  always_comb begin
    limit = (32'(cfg.row_length) < MAX_COLUMNS) ? LW'(cfg.row_length) : LW'(MAX_COLUMNS);
    start = LW'({item.index[dqi4_pkg::INDEX_W-1:dqi4_pkg::LANE_W], 3'b000});
    remain = limit - start;
    last_lane = (remain >= LW'(8)) ? 3'd7 : 3'(remain - LW'(1));
  end

  // Classify: decide whether the transaction leaves anything to do
  always_comb begin
    case (item.action)
      dqi4_pkg::ACT_SCALE:   keep = 32'(item.index) < MAX_GROUPS;
      dqi4_pkg::ACT_ZP:      keep = 32'(item.index) < ZP_DEPTH;
      dqi4_pkg::ACT_REORDER: keep = 32'(item.index) < MAX_COLUMNS;
      dqi4_pkg::ACT_DEQUANT: keep = limit > start;
      default:               keep = 1'b0;
    endcase
  end

  always_comb begin
    q_push.push          = item.valid && !q_full && keep;
    q_push.cmd.kind      = item.action;
    q_push.cmd.addr      = item.index;
    q_push.cmd.data      = item.data_value;
    q_push.cmd.codes     = item.packed_codes;
    q_push.cmd.last_lane = last_lane;
  end

endmodule

// ===== hw/rtl/dqi4_fifo.sv =====
// Short command queue between front and back end.
// Depends on dqi4_pkg for the command type and depth.
module dqi4_fifo (
  input  logic              clk,
  input  logic              rst,
  input  dqi4_pkg::q_push_t q_push,
  output logic              q_full,
  input  logic              pop,
  output dqi4_pkg::q_head_t q_head
);

  dqi4_pkg::cmd_t entries [dqi4_pkg::QUEUE_DEPTH];
  logic [dqi4_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [dqi4_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [dqi4_pkg::QUEUE_CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign q_full = count == dqi4_pkg::QUEUE_CW'(dqi4_pkg::QUEUE_DEPTH);
  assign do_push = q_push.push && !q_full;
  assign do_pop = pop && (count != '0);

  assign q_head.valid = count != '0;
  assign q_head.cmd = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dqi4_back.sv =====
// Back end: executes table writes and, while the output is not stalled, walks
// dequantize words one column a cycle through reorder read, scale/zero-point read,
// multiply and saturate. Depends on dqi4_pkg and dqi4_out_if.
module dqi4_back #(
  parameter int MAX_COLUMNS = dqi4_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_GROUPS  = dqi4_pkg::MAX_GROUPS_DEF,
  parameter int SCALE_BITS  = dqi4_pkg::SCALE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dqi4_pkg::cfg_t    cfg,
  input  dqi4_pkg::q_head_t q_head,
  output logic              pop,
  dqi4_out_if.source        result
);

  localparam int GW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int ZP_DEPTH = (MAX_GROUPS + 1) / 2;
  localparam int ZAW      = (ZP_DEPTH > 1) ? $clog2(ZP_DEPTH) : 1;
  localparam int RO_DEPTH = (MAX_COLUMNS < 4096) ? MAX_COLUMNS : 4096;
  localparam int RAW      = $clog2(RO_DEPTH);
  localparam int PW       = SCALE_BITS + 6;
  localparam int EW       = (PW > 21) ? PW : 21;

  // Tables
  logic signed [SCALE_BITS-1:0]      scale_mem [MAX_GROUPS];
  logic [dqi4_pkg::ZP_BYTE_W-1:0]    zp_mem [ZP_DEPTH];
  logic [GW:0]                       ro_mem [RO_DEPTH];

  logic advance;
  logic is_write;
  logic issue;
  logic [dqi4_pkg::LANE_W-1:0] lane;
  logic                        lane_last;
  logic [dqi4_pkg::COLUMN_W-1:0] issue_col;
  logic [dqi4_pkg::CODE_W-1:0]   issue_code;

  // Stage 1: column issued, reorder entry read
  logic                          s1_valid;
  logic [dqi4_pkg::COLUMN_W-1:0] s1_col;
  logic [dqi4_pkg::CODE_W-1:0]   s1_code;
  logic                          s1_last;
  logic [GW:0]                   ro_rdata;
  logic [dqi4_pkg::COLUMN_W-1:0] grp_shift;
  logic [GW-1:0]                 s1_grp;
  logic                          s1_oob;

  // Stage 2: scale and zero-point byte read
  logic                          s2_valid;
  logic [dqi4_pkg::COLUMN_W-1:0] s2_col;
  logic [dqi4_pkg::CODE_W-1:0]   s2_code;
  logic                          s2_last;
  logic                          s2_oob;
  logic                          s2_odd;
  logic signed [SCALE_BITS-1:0]  sc_rdata;
  logic [dqi4_pkg::ZP_BYTE_W-1:0] zp_rdata;
  logic [dqi4_pkg::CODE_W-1:0]   zp_val;
  logic signed [5:0]             diff;
  logic signed [PW-1:0]          diff_e;
  logic signed [PW-1:0]          scale_e;

  // Stage 3: product
  logic                          s3_valid;
  logic [dqi4_pkg::COLUMN_W-1:0] s3_col;
  logic                          s3_last;
  logic                          s3_oob;
  logic signed [PW-1:0]          s3_prod;
  logic signed [EW-1:0]          prod_e;
  logic signed [dqi4_pkg::RESULT_W-1:0] sat_val;

  // Output register
  logic                          out_valid;
  logic signed [dqi4_pkg::RESULT_W-1:0] out_value;
  logic [dqi4_pkg::COLUMN_W-1:0] out_col;
  logic                          out_last;

  // Whole pipeline moves when the output register is free or being taken
  assign advance = !out_valid || result.ready;

  assign is_write   = q_head.cmd.kind != dqi4_pkg::ACT_DEQUANT;
  assign issue      = advance && q_head.valid && !is_write;
  assign lane_last  = lane == q_head.cmd.last_lane;
  assign pop        = advance && q_head.valid && (is_write || lane_last);
  assign issue_col  = {q_head.cmd.addr[dqi4_pkg::INDEX_W-1:dqi4_pkg::LANE_W], lane};
  assign issue_code = q_head.cmd.codes[{lane, 2'b00} +: dqi4_pkg::CODE_W];

  // Lane counter over the columns of the head word
  always_ff @(posedge clk) begin
    if (rst) begin
      lane <= '0;
    end else if (pop) begin
      lane <= '0;
    end else if (issue) begin
      lane <= lane + 1'b1;
    end
  end

  // Scale table: write from queue head, read by stage 1 group
  always_ff @(posedge clk) begin
    if (advance && q_head.valid && q_head.cmd.kind == dqi4_pkg::ACT_SCALE) begin
      scale_mem[GW'(q_head.cmd.addr)] <= SCALE_BITS'(signed'(q_head.cmd.data));
    end
    if (advance) begin
      sc_rdata <= scale_mem[s1_grp];
    end
  end

  // Zero-point table, two nibbles per byte
  always_ff @(posedge clk) begin
    if (advance && q_head.valid && q_head.cmd.kind == dqi4_pkg::ACT_ZP) begin
      zp_mem[ZAW'(q_head.cmd.addr)] <= q_head.cmd.data[dqi4_pkg::ZP_BYTE_W-1:0];
    end
    if (advance) begin
      zp_rdata <= zp_mem[ZAW'(s1_grp >> 1)];
    end
  end

  // Reorder table; top bit marks a group beyond the scale table
  always_ff @(posedge clk) begin
    if (advance && q_head.valid && q_head.cmd.kind == dqi4_pkg::ACT_REORDER) begin
      ro_mem[RAW'(q_head.cmd.addr)] <= {32'(q_head.cmd.data) >= MAX_GROUPS,
                                        GW'(q_head.cmd.data)};
    end
    if (advance) begin
      ro_rdata <= ro_mem[RAW'(issue_col)];
    end
  end

  // Group select
  always_comb begin
    grp_shift = s1_col >> cfg.block_size_log2;
    if (cfg.reorder_enabled) begin
      s1_grp = ro_rdata[GW-1:0];
      s1_oob = ro_rdata[GW];
    end else begin
      s1_grp = GW'(grp_shift);
      s1_oob = 32'(grp_shift) >= MAX_GROUPS;
    end
  end

  // Zero point and signed difference
  always_comb begin
    if (cfg.zero_points_enabled) begin
      zp_val = s2_odd ? zp_rdata[7:4] : zp_rdata[3:0];
    end else begin
      zp_val = dqi4_pkg::ZP_FIXED;
    end
    diff    = $signed({2'b00, s2_code}) - $signed({2'b00, zp_val});
    diff_e  = PW'(diff);
    scale_e = PW'(sc_rdata);
  end

  // Saturate to the result range; out-of-range groups give zero
  always_comb begin
    prod_e = EW'(s3_prod);
    if (s3_oob) begin
      sat_val = '0;
    end else if (prod_e > EW'(dqi4_pkg::RES_MAX)) begin
      sat_val = dqi4_pkg::RESULT_W'(dqi4_pkg::RES_MAX);
    end else if (prod_e < EW'(dqi4_pkg::RES_MIN)) begin
      sat_val = dqi4_pkg::RESULT_W'(dqi4_pkg::RES_MIN);
    end else begin
      sat_val = prod_e[dqi4_pkg::RESULT_W-1:0];
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col    <= issue_col;
      s1_code   <= issue_code;
      s1_last   <= lane_last;
      s2_col    <= s1_col;
      s2_code   <= s1_code;
      s2_last   <= s1_last;
      s2_oob    <= s1_oob;
      s2_odd    <= s1_grp[0];
      s3_col    <= s2_col;
      s3_last   <= s2_last;
      s3_oob    <= s2_oob;
      s3_prod   <= diff_e * scale_e;
      out_value <= sat_val;
      out_col   <= s3_col;
      out_last  <= s3_last;
    end
  end

  assign result.valid             = out_valid;
  assign result.dequantized_value = out_value;
  assign result.column            = out_col;
  assign result.last              = out_last;

endmodule

// ===== hw/rtl/dequantize_int4_blockwise.sv =====
// Blockwise int4 dequantizer: the back end executes a table write from the queue head;
// a dequantize word gives one column per cycle inside the row (1 to 8) while the output
// is not stalled, set by the single column-wide back-end pipeline.
// Reset clears control and config registers; the tables are not cleared and
// hold unknown data until written.
module dequantize_int4_blockwise #(
  parameter int MAX_COLUMNS = dqi4_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_GROUPS  = dqi4_pkg::MAX_GROUPS_DEF,
  parameter int SCALE_BITS  = dqi4_pkg::SCALE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  dqi4_in_if.sink                             item,
  dqi4_out_if.source                          result,
  input  logic                                cfg_write,
  input  logic [dqi4_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dqi4_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dqi4_pkg::cfg_t    cfg;
  dqi4_pkg::q_push_t q_push;
  dqi4_pkg::q_head_t q_head;
  logic              q_full;
  logic              pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size_log2     <= dqi4_pkg::BLOCK_SIZE_LOG2_RST;
      cfg.row_length          <= dqi4_pkg::ROW_LENGTH_RST;
      cfg.zero_points_enabled <= 1'b0;
      cfg.reorder_enabled     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        dqi4_pkg::REG_BLOCK_SIZE_LOG2: cfg.block_size_log2     <= cfg_data[3:0];
        dqi4_pkg::REG_ROW_LENGTH:      cfg.row_length          <= cfg_data[12:0];
        dqi4_pkg::REG_ZP_ENABLE:       cfg.zero_points_enabled <= cfg_data[0];
        dqi4_pkg::REG_REORDER_ENABLE:  cfg.reorder_enabled     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dqi4_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .item  (item),
    .cfg   (cfg),
    .q_full(q_full),
    .q_push(q_push)
  );

  dqi4_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .q_push(q_push),
    .q_full(q_full),
    .pop   (pop),
    .q_head(q_head)
  );

  dqi4_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_GROUPS (MAX_GROUPS),
    .SCALE_BITS (SCALE_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .q_head(q_head),
    .pop   (pop),
    .result(result)
  );

endmodule

// ===== hw/rtl/dqi4_checker.sv =====
// Port-level checker for the int4 dequantizer, bound to the top level.
// Depends on dqi4_pkg and the assertion macros in the defines header.
`include "dequantize_int4_blockwise_defines.svh"

module dqi4_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [dqi4_pkg::RESULT_W-1:0] out_value,
  input logic [dqi4_pkg::COLUMN_W-1:0]        out_column,
  input logic                                 out_last
);

  // A stalled result holds its transaction
  `DQI4_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_column) && $stable(out_last))

  // No result is pending right after reset
  `DQI4_ASSERT_IMPLY(a_reset_empty, clk, 1'b0, $past(rst), !out_valid)

  // The eighth column of a word is always the final one of that word
  `DQI4_ASSERT_IMPLY(a_lane7_last, clk, rst, out_valid && (out_column[2:0] == 3'd7), out_last)

endmodule

bind dequantize_int4_blockwise dqi4_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.dequantized_value),
  .out_column(result.column),
  .out_last  (result.last)
);

// ===== tb/dqi4_dequant_check.sv =====
// Result checker for the blockwise int4 dequantizer: watches the item, result and
// register ports, predicts every dequantized element and compares in order.
// Depends on dqi4_pkg and the dqi4_in_if / dqi4_out_if channel interfaces.
module dqi4_dequant_check (
  input  logic                              clk,
  input  logic                              rst,
  dqi4_in_if                                item,
  dqi4_out_if                               result,
  input  logic                              cfg_write,
  input  logic [dqi4_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dqi4_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int unsigned                       mismatches,
  output int unsigned                       outstanding,
  output int unsigned                       checked
);
  import dqi4_pkg::*;

  localparam int GROUPS   = MAX_GROUPS_DEF;
  localparam int ZP_BYTES = (MAX_GROUPS_DEF + 1) / 2;
  localparam int COLUMNS  = MAX_COLUMNS_DEF;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic [COLUMN_W-1:0]        column;
    logic                       last;
  } elem_t;

  // Shadow copy of the row tables and registers
  logic signed [DATA_W-1:0] scale_mem [GROUPS];
  logic [ZP_BYTE_W-1:0]     zp_mem [ZP_BYTES];
  logic [DATA_W-1:0]        group_of_col [COLUMNS];
  cfg_t                     cfg;

  // Dequantized elements still owed by the block, oldest first
  elem_t pending_elems [$];

  // Expand one packed word into the elements it must produce
  task automatic predict_word(input logic [INDEX_W-1:0] start, input logic [CODES_W-1:0] codes);
    int    col;
    int    grp;
    int    zp;
    int    prod;
    int    first;
    elem_t e;
    first = pending_elems.size();
    for (int i = 0; i < 8; i++) begin
      // unaligned start columns drop their low three bits
      col = int'({start[INDEX_W-1:3], 3'b000}) + i;
      if (col >= int'(cfg.row_length) || col >= COLUMNS) continue;
      grp  = cfg.reorder_enabled ? int'(group_of_col[col]) : (col >> cfg.block_size_log2);
      prod = 0;
      // groups past the table give zero
      if (grp < GROUPS) begin
        zp = int'(ZP_FIXED);
        if (cfg.zero_points_enabled) begin
          zp = grp[0] ? int'(zp_mem[grp >> 1][7:4]) : int'(zp_mem[grp >> 1][3:0]);
        end
        prod = (int'(codes[4*i +: CODE_W]) - zp) * int'(scale_mem[grp]);
        if (prod > RES_MAX) prod = RES_MAX;
        if (prod < RES_MIN) prod = RES_MIN;
      end
      e.value  = RESULT_W'(prod);
      e.column = COLUMN_W'(col);
      e.last   = 1'b0;
      pending_elems.push_back(e);
    end
    // flag the final element of this word
    if (pending_elems.size() > first) begin
      e = pending_elems.pop_back();
      e.last = 1'b1;
      pending_elems.push_back(e);
    end
  endtask

  // Compare one result transaction with the oldest expected element
  task automatic check_result();
    elem_t want;
    if (pending_elems.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, got column %0d value %0d last %0b",
               $time, result.column, result.dequantized_value, result.last);
    end else begin
      want = pending_elems.pop_front();
      checked++;
      if (result.dequantized_value !== want.value) begin
        mismatches++;
        $display("%0t: value at column %0d: expected %0d, got %0d",
                 $time, want.column, want.value, result.dequantized_value);
      end
      if (result.column !== want.column) begin
        mismatches++;
        $display("%0t: column: expected %0d, got %0d", $time, want.column, result.column);
      end
      if (result.last !== want.last) begin
        mismatches++;
        $display("%0t: last at column %0d: expected %0b, got %0b",
                 $time, want.column, want.last, result.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      // tables keep their contents; only control state resets
      cfg.block_size_log2     = BLOCK_SIZE_LOG2_RST;
      cfg.row_length          = ROW_LENGTH_RST;
      cfg.zero_points_enabled = 1'b0;
      cfg.reorder_enabled     = 1'b0;
      pending_elems.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (result.valid && result.ready) check_result();

      if (cfg_write) begin
        case (cfg_index)
          REG_BLOCK_SIZE_LOG2: cfg.block_size_log2     = cfg_data[3:0];
          REG_ROW_LENGTH:      cfg.row_length          = cfg_data[12:0];
          REG_ZP_ENABLE:       cfg.zero_points_enabled = cfg_data[0];
          REG_REORDER_ENABLE:  cfg.reorder_enabled     = cfg_data[0];
          default: ;
        endcase
      end

      // accepted item: table update or new expectations
      if (item.valid && item.ready) begin
        case (item.action)
          ACT_SCALE: begin
            if (item.index < GROUPS) scale_mem[item.index] = item.data_value;
          end
          ACT_ZP: begin
            if (item.index < ZP_BYTES) zp_mem[item.index] = item.data_value[ZP_BYTE_W-1:0];
          end
          ACT_REORDER: begin
            if (item.index < COLUMNS) group_of_col[item.index] = item.data_value;
          end
          default: predict_word(item.index, item.packed_codes);
        endcase
      end
    end
    outstanding = pending_elems.size();
  end

endmodule

// ===== tb/dequantize_int4_blockwise_tb.sv =====
// Top of the blockwise int4 dequantizer testbench: clock, reset, stimulus, result
// back-pressure, watchdog and verdict. Depends on dqi4_pkg, the channel
// interfaces, the dequantizer and the dqi4_dequant_check result checker.
module dequantize_int4_blockwise_tb;
  import dqi4_pkg::*;

  localparam int GROUPS        = MAX_GROUPS_DEF;
  localparam int ZP_BYTES      = (MAX_GROUPS_DEF + 1) / 2;
  localparam int COLUMNS       = MAX_COLUMNS_DEF;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            mismatches;
  int unsigned            outstanding;
  int unsigned            checked;

  dqi4_in_if  item_ch ();
  dqi4_out_if result_ch ();

  dequantize_int4_blockwise dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dqi4_dequant_check dequant_check (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Stimulus view of registers and of which table entries hold data
  int              cur_blk;
  int              cur_row;
  bit              cur_zp;
  bit              cur_remap;
  bit              scale_set [GROUPS];
  bit              zp_set [ZP_BYTES];
  bit              map_set [COLUMNS];
  logic [DATA_W-1:0] map_val [COLUMNS];

  int sent_items;
  int settings_used;
  int hold_asks;
  int hold_served;
  int hold_left;
  int idle_run;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !(snk_idle_on && $urandom_range(99) < 33);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("dequantize_int4_blockwise test failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Offer one item until accepted, then record what it wrote
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] dat, input logic [CODES_W-1:0] codes);
    while (src_idle_on && $urandom_range(99) < 33) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.action       <= act;
    item_ch.index        <= idx;
    item_ch.data_value   <= dat;
    item_ch.packed_codes <= codes;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    case (act)
      ACT_SCALE:   if (idx < GROUPS) scale_set[idx] = 1'b1;
      ACT_ZP:      if (idx < ZP_BYTES) zp_set[idx] = 1'b1;
      ACT_REORDER: begin
        map_set[idx] = 1'b1;
        map_val[idx] = dat;
      end
      default: ;
    endcase
    sent_items++;
    @(negedge clk);
  endtask

  // Write all four registers; only called with the block idle
  task automatic configure(input int blk, input int row, input bit zp_on, input bit remap_on);
    cfg_write <= 1'b1;
    cfg_index <= REG_BLOCK_SIZE_LOG2;
    cfg_data  <= CFG_DATA_W'(blk);
    @(negedge clk);
    cfg_index <= REG_ROW_LENGTH;
    cfg_data  <= CFG_DATA_W'(row);
    @(negedge clk);
    cfg_index <= REG_ZP_ENABLE;
    cfg_data  <= CFG_DATA_W'(zp_on);
    @(negedge clk);
    cfg_index <= REG_REORDER_ENABLE;
    cfg_data  <= CFG_DATA_W'(remap_on);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_blk   = blk;
    cur_row   = row;
    cur_zp    = zp_on;
    cur_remap = remap_on;
    settings_used++;
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed result, then let trailing writes retire
  task automatic wait_quiet();
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly small groups so entries get reused; some anywhere, some past the table
  function automatic logic [DATA_W-1:0] pick_group();
    int r;
    r = $urandom_range(99);
    if (r < 70) return DATA_W'($urandom_range(31));
    if (r < 90) return DATA_W'($urandom_range(GROUPS - 1));
    return DATA_W'($urandom);
  endfunction

  // Fill any table entry the word will read, then send the word itself
  task automatic issue_word(input int start, input logic [CODES_W-1:0] codes);
    int base;
    int col;
    int grp;
    base = (start / 8) * 8;
    for (int i = 0; i < 8; i++) begin
      col = base + i;
      if (col < cur_row) begin
        if (cur_remap && !map_set[col]) begin
          send_item(ACT_REORDER, INDEX_W'(col), pick_group(), CODES_W'($urandom));
        end
        grp = cur_remap ? int'(map_val[col]) : (col >> cur_blk);
        if (grp < GROUPS) begin
          if (!scale_set[grp]) begin
            send_item(ACT_SCALE, INDEX_W'(grp), DATA_W'($urandom), CODES_W'($urandom));
          end
          if (!zp_set[grp >> 1]) begin
            send_item(ACT_ZP, INDEX_W'(grp >> 1), DATA_W'($urandom), CODES_W'($urandom));
          end
        end
      end
    end
    send_item(ACT_DEQUANT, INDEX_W'(start), DATA_W'($urandom), codes);
  endtask

  // Random traffic: well-formed words in a column window, plus stray writes
  // and words that fall wholly past the row
  task automatic run_random(input int budget, input int lo, input int hi);
    int stop;
    int r;
    int col_hi;
    int start;
    stop = sent_items + budget;
    while (sent_items < stop) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(ACTION_W'($urandom_range(ACT_REORDER)), INDEX_W'($urandom),
                  DATA_W'($urandom), CODES_W'($urandom));
      end else if (r < 15 && cur_row <= COLUMNS - 8) begin
        start = $urandom_range(COLUMNS - 1, ((cur_row + 7) / 8) * 8);
        send_item(ACT_DEQUANT, INDEX_W'(start), DATA_W'($urandom), CODES_W'($urandom));
      end else begin
        col_hi = (hi < cur_row - 1) ? hi : cur_row - 1;
        if ($urandom_range(9) == 0 || lo > col_hi) start = col_hi;
        else start = $urandom_range(col_hi, lo);
        issue_word(start, CODES_W'($urandom));
      end
    end
  endtask

  initial begin
    item_ch.valid        = 1'b0;
    item_ch.action       = ACT_SCALE;
    item_ch.index        = '0;
    item_ch.data_value   = '0;
    item_ch.packed_codes = '0;
    cfg_write            = 1'b0;
    cfg_index            = REG_BLOCK_SIZE_LOG2;
    cfg_data             = '0;
    rst                  = 1'b1;
    cur_blk              = BLOCK_SIZE_LOG2_RST;
    cur_row              = ROW_LENGTH_RST;
    cur_zp               = 1'b0;
    cur_remap            = 1'b0;
    settings_used        = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings: scale extremes, ignored writes, code extremes,
    // unaligned starts and the last word of the row
    send_item(ACT_SCALE, 12'd0, 16'h7FFF, 32'h0);
    send_item(ACT_SCALE, 12'd1, 16'h8000, 32'h0);
    send_item(ACT_SCALE, 12'd127, 16'h1000, 32'h0);
    send_item(ACT_ZP, 12'd0, 16'h00F0, 32'h0);
    send_item(ACT_ZP, 12'd63, 16'h005A, 32'h0);
    send_item(ACT_SCALE, 12'd4095, 16'h1234, 32'hFFFF_FFFF);
    send_item(ACT_ZP, 12'd256, 16'hFFFF, 32'h0);
    send_item(ACT_DEQUANT, 12'd0, 16'h0, 32'hFFFF_FFFF);
    send_item(ACT_DEQUANT, 12'd0, 16'hFFFF, 32'h0);
    send_item(ACT_DEQUANT, 12'd37, 16'h0, 32'h0F0F_0F0F);
    send_item(ACT_DEQUANT, 12'd4095, 16'h0, 32'h89AB_CDEF);
    wait_quiet();

    // Directed, three-column row with zero points and reordering: largest
    // product, a group past the table, and a word wholly outside the row
    configure(BLOCK_SIZE_LOG2_RST, 3, 1'b1, 1'b1);
    send_item(ACT_REORDER, 12'd0, 16'd1, 32'h0);
    send_item(ACT_REORDER, 12'd1, 16'hFFFF, 32'h0);
    send_item(ACT_REORDER, 12'd2, 16'd0, 32'h0);
    send_item(ACT_REORDER, 12'd4095, 16'd511, 32'h0);
    send_item(ACT_DEQUANT, 12'd0, 16'h0, 32'h1234_5F70);
    send_item(ACT_DEQUANT, 12'd8, 16'h0, 32'hFFFF_FFFF);
    wait_quiet();

    // Block size of eight columns, full row
    configure(3, COLUMNS, 1'b1, 1'b0);
    run_random(90, 0, COLUMNS - 1);
    wait_quiet();

    // Block size of 2048 columns, single-column row
    configure(11, 1, 1'b1, 1'b1);
    run_random(30, 0, 63);
    wait_quiet();

    // Reordered groups over a short row that may end mid-word
    configure(4, $urandom_range(300, 9), 1'b0, 1'b1);
    run_random(100, 0, 127);
    wait_quiet();

    // One column per group, most of them past the table; widest row value
    configure(0, 8191, 1'b1, 1'b0);
    run_random(60, 480, 600);
    wait_quiet();

    // Every column in group zero, with no idling on either side
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    configure(15, COLUMNS, 1'b0, 1'b0);
    run_random(70, 0, COLUMNS - 1);
    wait_quiet();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    // Random settings; the result side holds off so the block backs up
    configure($urandom_range(11, 3), $urandom_range(COLUMNS, 1), 1'b1, 1'b1);
    hold_asks++;
    run_random(100, 0, 63);

    wait_quiet();
    $display("Sent %0d input transactions under %0d register settings; checked %0d results.",
             sent_items, settings_used, checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("dequantize_int4_blockwise test passed");
    end else begin
      $display("dequantize_int4_blockwise test failed");
    end
    $finish;
  end

endmodule
